### design/alids_pkg.sv
// Shared types and constants for the array list block.
// No dependencies; imported by every module of the block.
package alids_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int OUT_LIMIT    = 64;
    localparam int FUNC_W       = 3;
    localparam int DATA_W       = 32;
    localparam int POS_W        = 7;
    localparam int STATUS_W     = 3;
    localparam int WHERE_W      = 6;

    typedef enum logic [FUNC_W-1:0] {
        FN_INSERT  = 3'd0,
        FN_DEL_IDX = 3'd1,
        FN_DEL_VAL = 3'd2,
        FN_SEARCH  = 3'd3,
        FN_DISPLAY = 3'd4
    } t_func;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_BOUNDS   = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_NOTFOUND = 3'd3,
        ST_FULL     = 3'd4,
        ST_BADOP    = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        CO_HOLD   = 2'd0,
        CO_INSERT = 2'd1,
        CO_REMOVE = 2'd2,
        CO_ROTATE = 2'd3
    } t_cell_op;

    typedef struct packed {
        logic [FUNC_W-1:0]        func;
        logic signed [DATA_W-1:0] value;
        logic [POS_W-1:0]         position;
    } t_in_req;

    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic signed [DATA_W-1:0] data;
        logic [WHERE_W-1:0]       where;
        logic                     last;
    } t_out_req;

    typedef struct packed {
        t_cell_op                 op;
        logic signed [DATA_W-1:0] value;
    } t_cell_cmd;

endpackage

### design/array_list_insert_delete_search_top.sv
// Array list top: a chain of CAPACITY cells and the sequencer that drives it.
// Insert, bad operation and empty or bounds errors: S_EXEC decides and loads the result.
// Search, delete at index, delete by value: S_SCAN rotates the cell chain past the head
// cell, then S_FIN issues the result. Display: one result per cycle unless the output stalls.
// One request in flight; the next is taken once its last result is issued.
// Reset clears the count and the result valid, not the entries. Needs alids_pkg/cell/ctrl.
module array_list_insert_delete_search_top import alids_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_in_req  i_in_req,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    output t_out_req o_out_req
);

    localparam int IW = $clog2(CAPACITY);

    t_cell_cmd                cmd;
    logic [IW-1:0]            cell_pos;
    logic [IW-1:0]            cell_last;
    logic signed [DATA_W-1:0] w_data [CAPACITY];

    alids_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_req    (i_in_req),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_req   (o_out_req),
        .i_head      (w_data[0]),
        .o_cmd       (cmd),
        .o_pos       (cell_pos),
        .o_last      (cell_last)
    );

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        localparam int L = (g == 0) ? 0 : g - 1;
        localparam int R = (g == CAPACITY - 1) ? g : g + 1;
        alids_cell #(
            .IW  (IW),
            .IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_cmd   (cmd),
            .i_pos   (cell_pos),
            .i_last  (cell_last),
            .i_left  (w_data[L]),
            .i_right (w_data[R]),
            .i_wrap  (w_data[0]),
            .o_data  (w_data[g])
        );
    end

    a_idle_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> cmd.op == CO_HOLD)
        else $error("cell chain moved while idle");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("request taken while previous one in progress");

    a_edit_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.op == CO_INSERT || cmd.op == CO_REMOVE) |=> o_out_valid)
        else $error("list edit without a result");

    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_req.status != ST_OK) |->
        (o_out_req.data == 32'sd0 && o_out_req.where == '0 && o_out_req.last))
        else $error("error result carries payload");

endmodule

### design/alids_cell.sv
// One storage cell of the list chain: holds one entry and loads from a neighbor, the head or the insert value.
// Depends on alids_pkg for the cell command type.
module alids_cell import alids_pkg::*; #(
    parameter int IW  = 6,
    parameter int IDX = 0
) (
    input  logic                     i_clk,
    input  t_cell_cmd                i_cmd,
    input  logic [IW-1:0]            i_pos,
    input  logic [IW-1:0]            i_last,
    input  logic signed [DATA_W-1:0] i_left,
    input  logic signed [DATA_W-1:0] i_right,
    input  logic signed [DATA_W-1:0] i_wrap,
    output logic signed [DATA_W-1:0] o_data
);

    localparam logic [IW-1:0] MY_IDX = IW'(IDX);

    logic signed [DATA_W-1:0] r_data;
    logic signed [DATA_W-1:0] n_data;

    always_comb begin
        n_data = r_data;
        unique case (i_cmd.op)
            CO_INSERT: begin
                if (MY_IDX == i_pos) begin
                    n_data = i_cmd.value;
                end else if (MY_IDX > i_pos) begin
                    n_data = i_left;
                end
            end
            CO_REMOVE: begin
                if (MY_IDX >= i_pos) begin
                    n_data = i_right;
                end
            end
            CO_ROTATE: begin
                if (MY_IDX == i_last) begin
                    n_data = i_wrap;
                end else if (MY_IDX < i_last) begin
                    n_data = i_right;
                end
            end
            default: n_data = r_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

### design/alids_ctrl.sv
// Sequencer of the array list: decodes requests, drives the cell chain, scans
// through rotation and holds the result register. Depends on alids_pkg.
module alids_ctrl import alids_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  t_in_req                  i_in_req,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output t_out_req                 o_out_req,
    input  logic signed [DATA_W-1:0] i_head,
    output t_cell_cmd                o_cmd,
    output logic [$clog2(CAPACITY)-1:0] o_pos,
    output logic [$clog2(CAPACITY)-1:0] o_last
);

    localparam int IW   = $clog2(CAPACITY);
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = (CW > POS_W) ? CW : POS_W;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_SCAN = 4'b0100,
        S_FIN  = 4'b1000
    } t_state;

    t_state                   r_state, n_state;
    logic [CW-1:0]            r_count, n_count;
    logic                     r_out_valid, n_out_valid;
    t_out_req                 r_out, n_out;
    logic [FUNC_W-1:0]        r_func, n_func;
    logic signed [DATA_W-1:0] r_value, n_value;
    logic [POS_W-1:0]         r_pos, n_pos;
    logic [IW-1:0]            r_k, n_k;
    logic [IW-1:0]            r_idx, n_idx;
    logic                     r_hit, n_hit;
    logic signed [DATA_W-1:0] r_cap, n_cap;

    logic          slot_free;
    logic          emit;
    logic          step;
    logic [IW-1:0] last_idx;
    t_out_req      res;

    assign slot_free = !r_out_valid || i_out_ready;
    assign last_idx  = IW'(r_count - 1'b1);

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_func   = r_func;
        n_value  = r_value;
        n_pos    = r_pos;
        n_k      = r_k;
        n_idx    = r_idx;
        n_hit    = r_hit;
        n_cap    = r_cap;
        emit     = 1'b0;
        step     = 1'b0;
        res      = '0;
        res.last = 1'b1;
        o_cmd.op    = CO_HOLD;
        o_cmd.value = r_value;
        o_pos       = r_idx;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_func  = i_in_req.func;
                    n_value = i_in_req.value;
                    n_pos   = i_in_req.position;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_k   = '0;
                n_hit = 1'b0;
                n_idx = IW'(r_pos);
                unique case (r_func) inside
                    FN_INSERT: begin
                        if (slot_free) begin
                            emit    = 1'b1;
                            n_state = S_IDLE;
                            if (r_count == '0) begin
                                o_cmd.op   = CO_INSERT;
                                o_pos      = '0;
                                n_count    = CW'(1);
                                res.status = ST_OK;
                                res.data   = r_value;
                            end else if (int'(r_count) >= CAPACITY) begin
                                res.status = ST_FULL;
                            end else if (CMPW'(r_pos) > CMPW'(r_count)) begin
                                res.status = ST_BOUNDS;
                            end else begin
                                o_cmd.op   = CO_INSERT;
                                o_pos      = IW'(r_pos);
                                n_count    = r_count + 1'b1;
                                res.status = ST_OK;
                                res.data   = r_value;
                                res.where  = r_pos[WHERE_W-1:0];
                            end
                        end
                    end
                    FN_DEL_IDX: begin
                        if (r_count == '0 || CMPW'(r_pos) >= CMPW'(r_count)) begin
                            if (slot_free) begin
                                emit       = 1'b1;
                                res.status = (r_count == '0) ? ST_EMPTY : ST_BOUNDS;
                                n_state    = S_IDLE;
                            end
                        end else begin
                            n_state = S_SCAN;
                        end
                    end
                    FN_DEL_VAL, FN_SEARCH: begin
                        if (r_count == '0) begin
                            if (slot_free) begin
                                emit       = 1'b1;
                                res.status = (r_func == FN_SEARCH) ? ST_NOTFOUND : ST_EMPTY;
                                n_state    = S_IDLE;
                            end
                        end else begin
                            n_state = S_SCAN;
                        end
                    end
                    FN_DISPLAY: begin
                        if (r_count == '0) begin
                            if (slot_free) begin
                                emit       = 1'b1;
                                res.status = ST_EMPTY;
                                n_state    = S_IDLE;
                            end
                        end else begin
                            n_state = S_SCAN;
                        end
                    end
                    default: begin
                        if (slot_free) begin
                            emit       = 1'b1;
                            res.status = ST_BADOP;
                            n_state    = S_IDLE;
                        end
                    end
                endcase
            end
            S_SCAN: begin
                step = (r_func != FN_DISPLAY) || (int'(r_k) >= OUT_LIMIT) || slot_free;
                if (step) begin
                    o_cmd.op = CO_ROTATE;
                    n_k      = IW'(r_k + 1'b1);
                    if ((r_func == FN_DEL_VAL || r_func == FN_SEARCH)
                        && !r_hit && i_head == r_value) begin
                        n_hit = 1'b1;
                        n_idx = r_k;
                    end
                    if (r_func == FN_DEL_IDX && r_k == r_idx) begin
                        n_cap = i_head;
                    end
                    if (r_func == FN_DISPLAY && int'(r_k) < OUT_LIMIT) begin
                        emit       = 1'b1;
                        res.status = ST_OK;
                        res.data   = i_head;
                        res.where  = WHERE_W'(r_k);
                        res.last   = (r_k == last_idx) || (int'(r_k) == OUT_LIMIT - 1);
                    end
                    if (r_k == last_idx) begin
                        n_state = (r_func == FN_DISPLAY) ? S_IDLE : S_FIN;
                    end
                end
            end
            S_FIN: begin
                if (slot_free) begin
                    emit    = 1'b1;
                    n_state = S_IDLE;
                    if (r_func == FN_DEL_IDX) begin
                        o_cmd.op   = CO_REMOVE;
                        n_count    = r_count - 1'b1;
                        res.status = ST_OK;
                        res.data   = r_cap;
                        res.where  = WHERE_W'(r_idx);
                    end else if (r_hit) begin
                        if (r_func == FN_DEL_VAL) begin
                            o_cmd.op = CO_REMOVE;
                            n_count  = r_count - 1'b1;
                        end
                        res.status = ST_OK;
                        res.data   = r_value;
                        res.where  = WHERE_W'(r_idx);
                    end else begin
                        res.status = ST_NOTFOUND;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase

        n_out_valid = emit || (r_out_valid && !i_out_ready);
        n_out       = emit ? res : r_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out   <= n_out;
        r_func  <= n_func;
        r_value <= n_value;
        r_pos   <= n_pos;
        r_k     <= n_k;
        r_idx   <= n_idx;
        r_hit   <= n_hit;
        r_cap   <= n_cap;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_req   = r_out;
    assign o_last      = last_idx;

endmodule
